/* src/pse_pkg.sv */
package pse_pkg;

  localparam int unsigned NEURONS_DEF        = 256;
  localparam int unsigned SPIKE_LIMIT_DEF    = 64;
  localparam int unsigned LOG_TABLE_BITS_DEF = 10;

  localparam int unsigned TIME_W  = 48;
  localparam int unsigned RATE_W  = 24;
  localparam int unsigned STEP_W  = 25;
  localparam int unsigned SMP_W   = 16;
  localparam int unsigned NID_W   = 8;
  localparam int unsigned CNT_W   = 7;
  localparam int unsigned E_W     = 38;
  localparam int unsigned CFG_W   = 48;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [TIME_W-1:0] TIME_MAX     = 48'hFFFF_FFFF_FFFF;
  localparam logic [31:0]       LN2_Q32      = 32'd2977044472;
  localparam logic [31:0]       LCG_MUL_LO   = 32'hDEEC_E66D;
  localparam logic [31:0]       LCG_MUL_HI   = 32'h0000_0005;
  localparam logic [TIME_W-1:0] LCG_ADD      = 48'h0000_0000_000B;
  localparam logic [TIME_W-1:0] SEED_DEF     = 48'h1234_ABCD_330E;
  localparam logic [STEP_W-1:0] STEP_DEF     = 25'd16777;
  localparam logic [RATE_W-1:0] MIN_RATE_DEF = 24'd0;
  localparam logic [RATE_W-1:0] MAX_RATE_DEF = 24'd25600;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STEP_TIME = 2'd0,
    REG_MIN_RATE  = 2'd1,
    REG_MAX_RATE  = 2'd2,
    REG_RNG_SEED  = 2'd3
  } cfg_reg_e;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_READ, S_L0, S_L1, S_L2, S_TEST, S_NORM,
    S_LOG, S_E1, S_E2, S_DIV, S_APPLY, S_CHECK
  } state_e;

endpackage

/* src/pse_ram.sv */
module pse_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                clk_i,
  input  logic                                we_i,
  input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                    wdata_i,
  input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                    rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* src/pse_div.sv */
module pse_div
  import pse_pkg::*;
#(
  parameter int unsigned QW = 38,
  parameter int unsigned DW = 24
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [QW-1:0] dividend_i,
  input  logic [DW-1:0] divisor_i,
  output logic          done_o,
  output logic [QW-1:0] quot_o
);

  localparam int unsigned CW = $clog2(QW + 1);

  logic [DW-1:0] rem_q, rem_d, div_q, div_d;
  logic [QW-1:0] quo_q, quo_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          done_q, done_d;
  logic [DW:0]   shifted, diff;

  // one restoring step per cycle, quotient bits shift in at the bottom
  always_comb begin
    shifted = {rem_q, quo_q[QW-1]};
    diff    = shifted - {1'b0, div_q};
    rem_d   = rem_q;
    quo_d   = quo_q;
    div_d   = div_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    if (start_i) begin
      rem_d = '0;
      quo_d = dividend_i;
      div_d = divisor_i;
      cnt_d = CW'(QW);
    end else if (cnt_q != '0) begin
      if (shifted >= {1'b0, div_q}) begin
        rem_d = diff[DW-1:0];
        quo_d = {quo_q[QW-2:0], 1'b1};
      end else begin
        rem_d = shifted[DW-1:0];
        quo_d = {quo_q[QW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    div_q <= div_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

/* src/poisson_spike_encoder_core.sv */
// poisson rate spike encoder: one shared 32x32 multiplier under a sequencer, plus a
// restoring divider; an item takes a read step, then per draw the generator steps, a
// zero test, normalize, log squarings, scale, divide, add and check (a zero draw or
// rate skips to the add), or just the check when no draw is needed; one draw per spike,
// one item at a time; in_stall_o is high whenever the sequencer is not idle, so also
// while a beat waits on out_stall_i; reset (async, active low) clears control state,
// then sweeps the whole neuron memory before the first beat is taken
module poisson_spike_encoder_core
  import pse_pkg::*;
#(
  parameter int unsigned NEURONS        = NEURONS_DEF,
  parameter int unsigned SPIKE_LIMIT    = SPIKE_LIMIT_DEF,
  parameter int unsigned LOG_TABLE_BITS = LOG_TABLE_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // config write port
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_W-1:0]      cfg_data_i,
  // input beats
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [NID_W-1:0]      neuron_i,
  input  logic signed [SMP_W-1:0] rate_sample_i,
  input  logic                  tick_end_i,
  // output beats
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [NID_W-1:0]      spike_neuron_o,
  output logic [TIME_W-1:0]     spike_time_o,
  output logic                  last_o,
  output logic                  dropped_o
);

  localparam int unsigned AW    = (NEURONS > 1) ? $clog2(NEURONS) : 1;
  localparam int unsigned ENT_W = 1 + SMP_W + TIME_W;
  localparam int unsigned LTB   = LOG_TABLE_BITS;

  // config registers
  logic [STEP_W-1:0] step_q;
  logic [RATE_W-1:0] min_q, max_q;

  state_e state_q, state_d;

  // per item context
  logic [NID_W-1:0]  nid_q, nid_d;
  logic [SMP_W-1:0]  raw_q, raw_d;
  logic              tick_q, tick_d;
  logic [TIME_W-1:0] now_q, now_d;
  logic [TIME_W:0]   hor_q, hor_d;
  logic [RATE_W-1:0] rate_q, rate_d;
  logic [TIME_W-1:0] next_q, next_d;
  logic              first_q, first_d;
  logic              pend_q, pend_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;

  // draw datapath
  logic [TIME_W-1:0] lcg_q, lcg_d;
  logic [TIME_W-1:0] acc_q, acc_d;
  logic [TIME_W-1:0] xs_q, xs_d;
  logic [5:0]        lz_q, lz_d;
  logic [31:0]       y_q, y_d;
  logic [31:0]       l2_q, l2_d;
  logic [4:0]        k_q, k_d;
  logic [31:0]       t_q, t_d;
  logic [TIME_W-1:0] iv_q, iv_d;

  // clear sweep
  logic [AW-1:0]     clr_q, clr_d;

  // output register
  logic              ov_q, ov_d;
  logic [NID_W-1:0]  on_q, on_d;
  logic [TIME_W-1:0] ot_q, ot_d;
  logic              ol_q, ol_d, od_q, od_d;

  // shared multiplier
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  assign mul_p = mul_a * mul_b;

  // memory: {primed, seen rate, next spike time}
  logic              ram_we;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [ENT_W-1:0]  ram_wdata, ram_rdata;
  logic [15:0]       nid_ext_in, nid_ext_q;

  // divider
  logic              div_start, div_done;
  logic [E_W-1:0]    div_dividend, div_quot;

  logic              in_acc, slot_free, due, in_range;
  logic [RATE_W-1:0] rdiff;
  logic              rge;
  logic [32:0]       sq;
  logic [TIME_W:0]   sum;
  logic [TIME_W-1:0] base;
  logic [TIME_W-1:0] hor_sat;

  assign nid_ext_in = {8'b0, neuron_i};
  assign nid_ext_q  = {8'b0, nid_q};
  assign ram_raddr  = nid_ext_in[AW-1:0];
  assign in_range   = nid_ext_in < 16'(NEURONS);
  assign in_acc     = in_valid_i && (state_q == S_IDLE);
  assign in_stall_o = (state_q != S_IDLE);
  assign slot_free  = !ov_q || !out_stall_i;
  assign due        = {1'b0, next_q} < hor_q;
  assign hor_sat    = hor_q[TIME_W] ? TIME_MAX : hor_q[TIME_W-1:0];
  assign rge        = max_q >= min_q;
  assign rdiff      = rge ? (max_q - min_q) : (min_q - max_q);
  assign sq         = mul_p[63:31];
  assign base       = first_q ? now_q : next_q;
  assign sum        = {1'b0, base} + {1'b0, iv_q};

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_READ: begin
        mul_a = {16'b0, raw_q ^ 16'h8000};
        mul_b = {8'b0, rdiff};
      end
      S_L0: begin
        mul_a = lcg_q[31:0];
        mul_b = LCG_MUL_LO;
      end
      S_L1: begin
        mul_a = {16'b0, lcg_q[47:32]};
        mul_b = LCG_MUL_LO;
      end
      S_L2: begin
        mul_a = lcg_q[31:0];
        mul_b = LCG_MUL_HI;
      end
      S_LOG: begin
        mul_a = y_q;
        mul_b = y_q;
      end
      S_E1: begin
        mul_a = l2_q;
        mul_b = LN2_Q32;
      end
      S_E2: begin
        mul_a = {26'b0, lz_q + 6'd1};
        mul_b = LN2_Q32;
      end
      default: ;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: if (clr_q == AW'(NEURONS - 1)) state_d = S_IDLE;
      S_IDLE:  if (in_valid_i && in_range) state_d = S_READ;
      S_READ: begin
        if (!ram_rdata[ENT_W-1] || ram_rdata[ENT_W-2 -: SMP_W] != raw_q) begin
          state_d = S_L0;
        end else begin
          state_d = S_CHECK;
        end
      end
      S_L0:   state_d = S_L1;
      S_L1:   state_d = S_L2;
      S_L2:   state_d = S_TEST;
      S_TEST: state_d = (lcg_q == '0 || rate_q == '0) ? S_APPLY : S_NORM;
      S_NORM: if (xs_q[TIME_W-1]) state_d = S_LOG;
      S_LOG:  if (k_q == 5'd31) state_d = S_E1;
      S_E1:   state_d = S_E2;
      S_E2:   state_d = S_DIV;
      S_DIV:  if (div_done) state_d = S_APPLY;
      S_APPLY: state_d = S_CHECK;
      S_CHECK: begin
        if (due && (cnt_q < CNT_W'(SPIKE_LIMIT))) begin
          if (!pend_q || slot_free) state_d = S_L0;
        end else if (!pend_q || slot_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    nid_d   = nid_q;
    raw_d   = raw_q;
    tick_d  = tick_q;
    now_d   = now_q;
    hor_d   = hor_q;
    rate_d  = rate_q;
    next_d  = next_q;
    first_d = first_q;
    pend_d  = pend_q;
    cnt_d   = cnt_q;
    acc_d   = acc_q;
    xs_d    = xs_q;
    lz_d    = lz_q;
    y_d     = y_q;
    l2_d    = l2_q;
    k_d     = k_q;
    t_d     = t_q;
    iv_d    = iv_q;
    clr_d   = clr_q;
    ov_d    = ov_q && out_stall_i;
    on_d    = on_q;
    ot_d    = ot_q;
    ol_d    = ol_q;
    od_d    = od_q;
    ram_we    = 1'b0;
    ram_waddr = nid_ext_q[AW-1:0];
    ram_wdata = {1'b1, raw_q, next_q};
    div_start    = 1'b0;
    div_dividend = mul_p[E_W-1:0] - {6'b0, t_q};
    case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
        clr_d     = clr_q + 1'b1;
      end
      S_IDLE: begin
        if (in_acc) begin
          nid_d   = neuron_i;
          raw_d   = rate_sample_i;
          tick_d  = tick_end_i;
          hor_d   = {1'b0, now_q} + {24'b0, step_q};
          pend_d  = 1'b0;
          cnt_d   = '0;
          first_d = 1'b1;
          if (!in_range && tick_end_i) begin
            now_d = hor_d[TIME_W] ? TIME_MAX : hor_d[TIME_W-1:0];
          end
        end
      end
      S_READ: begin
        rate_d = rge ? (min_q + mul_p[39:16]) : (min_q - mul_p[39:16]);
        next_d = ram_rdata[TIME_W-1:0];
      end
      S_L0: acc_d = mul_p[TIME_W-1:0];
      S_L1: acc_d = acc_q + {mul_p[15:0], 32'b0};
      S_L2: xs_d  = acc_q + {mul_p[15:0], 32'b0} + LCG_ADD;
      S_TEST: begin
        iv_d = TIME_MAX;
        lz_d = '0;
      end
      S_NORM: begin
        if (xs_q[TIME_W-1]) begin
          y_d  = {1'b1, xs_q[TIME_W-2 -: LTB], {(31-LTB){1'b0}}};
          l2_d = '0;
          k_d  = '0;
        end else if (xs_q[TIME_W-1 -: 8] == '0) begin
          xs_d = {xs_q[TIME_W-9:0], 8'b0};
          lz_d = lz_q + 6'd8;
        end else begin
          xs_d = {xs_q[TIME_W-2:0], 1'b0};
          lz_d = lz_q + 6'd1;
        end
      end
      S_LOG: begin
        // repeated squaring yields log2 one bit per step
        if (sq[32]) begin
          l2_d[5'd31 - k_q] = 1'b1;
          y_d = sq[32:1];
        end else begin
          y_d = sq[31:0];
        end
        k_d = k_q + 1'b1;
      end
      S_E1: t_d = mul_p[63:32];
      S_E2: div_start = 1'b1;
      S_DIV: if (div_done) iv_d = {10'b0, div_quot};
      S_APPLY: begin
        next_d = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
      end
      S_CHECK: begin
        if (due && (cnt_q < CNT_W'(SPIKE_LIMIT))) begin
          if (!pend_q || slot_free) begin
            if (pend_q) begin
              ov_d = 1'b1;
              on_d = nid_q;
              ot_d = now_q;
              ol_d = 1'b0;
              od_d = 1'b0;
            end
            pend_d  = 1'b1;
            cnt_d   = cnt_q + 1'b1;
            first_d = 1'b0;
          end
        end else if (!pend_q || slot_free) begin
          // final beat of the item if one is pending, then write back, and advance time at a tick end
          if (pend_q) begin
            ov_d = 1'b1;
            on_d = nid_q;
            ot_d = now_q;
            ol_d = 1'b1;
            od_d = due;
          end
          ram_we    = 1'b1;
          ram_wdata = {1'b1, raw_q, (pend_q && due) ? hor_sat : next_q};
          if (tick_q) now_d = hor_sat;
        end
      end
      default: ;
    endcase
  end

  // generator state: seed write reloads, draw updates
  always_comb begin
    lcg_d = lcg_q;
    if (cfg_we_i && cfg_index_i == REG_RNG_SEED) begin
      lcg_d = cfg_data_i;
    end else if (state_q == S_L2) begin
      lcg_d = acc_q + {mul_p[15:0], 32'b0} + LCG_ADD;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      step_q  <= STEP_DEF;
      min_q   <= MIN_RATE_DEF;
      max_q   <= MAX_RATE_DEF;
      lcg_q   <= SEED_DEF;
      now_q   <= '0;
      ov_q    <= 1'b0;
      pend_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      lcg_q   <= lcg_d;
      now_q   <= now_d;
      ov_q    <= ov_d;
      pend_q  <= pend_d;
      cnt_q   <= cnt_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_STEP_TIME: step_q <= cfg_data_i[STEP_W-1:0];
          REG_MIN_RATE:  min_q  <= cfg_data_i[RATE_W-1:0];
          REG_MAX_RATE:  max_q  <= cfg_data_i[RATE_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    nid_q   <= nid_d;
    raw_q   <= raw_d;
    tick_q  <= tick_d;
    hor_q   <= hor_d;
    rate_q  <= rate_d;
    next_q  <= next_d;
    first_q <= first_d;
    acc_q   <= acc_d;
    xs_q    <= xs_d;
    lz_q    <= lz_d;
    y_q     <= y_d;
    l2_q    <= l2_d;
    k_q     <= k_d;
    t_q     <= t_d;
    iv_q    <= iv_d;
    on_q    <= on_d;
    ot_q    <= ot_d;
    ol_q    <= ol_d;
    od_q    <= od_d;
  end

  pse_ram #(
    .WIDTH(ENT_W),
    .DEPTH(NEURONS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  pse_div #(
    .QW(E_W),
    .DW(RATE_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (rate_q),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  assign out_valid_o    = ov_q;
  assign spike_neuron_o = on_q;
  assign spike_time_o   = ot_q;
  assign last_o         = ol_q;
  assign dropped_o      = od_q;

endmodule

/* test/poisson_spike_encoder_core_test.sv */
`timescale 1ns / 100ps

module poisson_spike_encoder_core_test;
  import pse_pkg::*;

  typedef struct packed {
    logic [NID_W-1:0]  neuron;
    logic [TIME_W-1:0] stamp;
    logic              last;
    logic              dropped;
  } spike_t;

  localparam int unsigned TBL_BITS   = LOG_TABLE_BITS_DEF;
  localparam int unsigned CYCLE_CAP  = 20000000;
  localparam int unsigned DRAIN_WAIT = 400;

  // scoreboard: carries its own copy of the encoder state and predicts spikes
  class spike_scoreboard;
    logic [63:0] ln_mant [1 << TBL_BITS];
    logic [63:0] step_len, rate_lo, rate_hi, lcg, now_t;
    logic [15:0] seen [256];
    logic [63:0] due_at [256];
    bit          primed [256];
    spike_t      pending [$];
    int          mismatches;

    function new();
      logic [63:0] y, l2;
      for (int i = 0; i < (1 << TBL_BITS); i++) begin
        y  = (64'd1 << 31) + (64'(i) << (31 - TBL_BITS));
        l2 = 0;
        for (int k = 0; k < 32; k++) begin
          y = (y * y) >> 31;
          if (y >= (64'd1 << 32)) begin
            l2 |= 64'd1 << (31 - k);
            y = y >> 1;
          end
        end
        ln_mant[i] = (l2 * 64'(LN2_Q32)) >> 32;
      end
      step_len = 64'(STEP_DEF);
      rate_lo  = 64'(MIN_RATE_DEF);
      rate_hi  = 64'(MAX_RATE_DEF);
      lcg      = 64'(SEED_DEF);
      now_t    = 0;
      for (int i = 0; i < 256; i++) begin
        seen[i] = 0; due_at[i] = 0; primed[i] = 0;
      end
      mismatches = 0;
    endfunction

    function void write_reg(cfg_reg_e idx, logic [CFG_W-1:0] v);
      case (idx)
        REG_STEP_TIME: step_len = 64'(v[STEP_W-1:0]);
        REG_MIN_RATE:  rate_lo  = 64'(v[RATE_W-1:0]);
        REG_MAX_RATE:  rate_hi  = 64'(v[RATE_W-1:0]);
        REG_RNG_SEED:  lcg      = 64'(v);
        default: ;
      endcase
    endfunction

    function logic [63:0] sat48(logic [63:0] a);
      return (a > 64'(TIME_MAX)) ? 64'(TIME_MAX) : a;
    endfunction

    // one exponential interval in Q24.24 seconds
    function logic [63:0] interval(logic [63:0] r);
      logic [63:0] x, idx, e;
      int p;
      lcg = (lcg * 64'h5DEECE66D + 64'd11) & 64'hFFFF_FFFF_FFFF;
      x = lcg;
      if (x == 0 || r == 0) return 64'(TIME_MAX);
      p = 47;
      while (x[p] == 1'b0) p--;
      if (p >= TBL_BITS) idx = (x >> (p - TBL_BITS)) & 64'((1 << TBL_BITS) - 1);
      else idx = (x << (TBL_BITS - p)) & 64'((1 << TBL_BITS) - 1);
      e = 64'(48 - p) * 64'(LN2_Q32) - ln_mant[idx];
      return e / r;
    endfunction

    function void note_input(logic [7:0] n, logic [15:0] raw, logic tick);
      logic [63:0] prod, r, horizon;
      int cnt;
      spike_t s;
      prod = 64'(raw ^ 16'h8000);
      if (rate_hi >= rate_lo) r = rate_lo + ((prod * (rate_hi - rate_lo)) >> 16);
      else r = rate_lo - ((prod * (rate_lo - rate_hi)) >> 16);
      horizon = now_t + step_len;
      if (!primed[n] || seen[n] != raw) begin
        due_at[n] = sat48(now_t + interval(r));
        seen[n]   = raw;
        primed[n] = 1;
      end
      cnt = 0;
      while (due_at[n] < horizon && cnt < SPIKE_LIMIT_DEF) begin
        s = '{neuron: n, stamp: now_t[TIME_W-1:0], last: 0, dropped: 0};
        pending.push_back(s);
        cnt++;
        due_at[n] = sat48(due_at[n] + interval(r));
      end
      if (cnt > 0) begin
        pending[$].last = 1;
        if (due_at[n] < horizon) begin
          due_at[n] = sat48(horizon);
          pending[$].dropped = 1;
        end
      end
      if (tick) now_t = sat48(now_t + step_len);
    endfunction

    function void check_result(spike_t got);
      spike_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected spike beat: neuron %0d time %h", got.neuron, got.stamp);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("spike mismatch: want n=%0d t=%h l=%b d=%b, got n=%0d t=%h l=%b d=%b",
                   want.neuron, want.stamp, want.last, want.dropped,
                   got.neuron, got.stamp, got.last, got.dropped);
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic cfg_we;
  cfg_reg_e cfg_index;
  logic [CFG_W-1:0] cfg_data;
  logic in_valid, in_stall;
  logic [NID_W-1:0] neuron;
  logic signed [SMP_W-1:0] rate_sample;
  logic tick_end;
  logic out_valid, out_stall;
  logic [NID_W-1:0] spike_neuron;
  logic [TIME_W-1:0] spike_time;
  logic last, dropped;

  spike_scoreboard sb;
  int unsigned cycles;
  bit long_hold;
  bit hold_go;
  logic [15:0] held_rate [8];

  poisson_spike_encoder_core dut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_we_i(cfg_we), .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .neuron_i(neuron), .rate_sample_i(rate_sample), .tick_end_i(tick_end),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .spike_neuron_o(spike_neuron), .spike_time_o(spike_time),
    .last_o(last), .dropped_o(dropped)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // watchdog, sized from the slowest legal run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // monitor: values read here are the ones seen at the edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_input(neuron, rate_sample, tick_end);
      if (out_valid && !out_stall)
        sb.check_result('{neuron: spike_neuron, stamp: spike_time,
                          last: last, dropped: dropped});
    end
  end

  // receiver stall: mostly short random gaps, some runs free, one long hold-off
  always @(posedge clk) begin
    if (long_hold) out_stall <= 1'b1;
    else if ($urandom_range(0, 99) < 20) out_stall <= 1'b1;
    else out_stall <= 1'b0;
  end

  // long hold-off, started once the sender is busy with a random phase
  initial begin
    long_hold = 0;
    wait (hold_go);
    repeat (200) @(posedge clk);
    long_hold = 1;
    repeat (3000) @(posedge clk);
    long_hold = 0;
  end

  task automatic idle_gap();
    int k;
    k = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) k = 0;
    if (k > 0) begin
      in_valid <= 1'b0;
      repeat (k) @(posedge clk);
    end
  endtask

  // offer one beat and hold it until taken
  task automatic send_rate(logic [7:0] n, logic [15:0] s, logic t);
    in_valid    <= 1'b1;
    neuron      <= n;
    rate_sample <= s;
    tick_end    <= t;
    do @(posedge clk); while (in_stall);
    idle_gap();
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // one register write; the caller drops the write enable after a run of writes
  task automatic write_reg(cfg_reg_e idx, logic [CFG_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    sb.write_reg(idx, v);
  endtask

  task automatic configure(logic [CFG_W-1:0] st, logic [CFG_W-1:0] lo,
                           logic [CFG_W-1:0] hi, logic [CFG_W-1:0] seed);
    write_reg(REG_STEP_TIME, st);
    write_reg(REG_MIN_RATE, lo);
    write_reg(REG_MAX_RATE, hi);
    write_reg(REG_RNG_SEED, seed);
    cfg_we <= 1'b0;
  endtask

  // random traffic: a few hot neurons with stable rates, some noise
  task automatic random_run(int count);
    logic [7:0] n;
    logic [15:0] s;
    for (int i = 0; i < 8; i++) held_rate[i] = 16'($urandom);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        n = 8'($urandom_range(0, 255));
        s = 16'($urandom);
      end else begin
        n = 8'($urandom_range(0, 7));
        if ($urandom_range(0, 9) < 2) held_rate[n] = 16'($urandom);
        s = held_rate[n];
      end
      send_rate(n, s, 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    sb = new();
    cycles = 0;
    rst_n = 0;
    cfg_we = 0;
    cfg_index = REG_STEP_TIME;
    cfg_data = 0;
    in_valid = 0;
    neuron = 0;
    rate_sample = 0;
    tick_end = 0;
    out_stall = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset values: low rates, mostly no spikes
    send_rate(8'd3, 16'h7FFF, 1'b1);
    send_rate(8'd255, 16'h8000, 1'b1);
    settle();

    // one second ticks at full rate: spike limit and discarded spikes
    configure(48'd16777216, 48'd0, 48'hFFFFFF, 48'h1234ABCD330E);
    send_rate(8'd0, 16'h7FFF, 1'b0);
    send_rate(8'd0, 16'h7FFF, 1'b1);
    send_rate(8'd255, 16'h8000, 1'b0);  // zero rate saturates
    send_rate(8'd1, 16'h0000, 1'b1);
    send_rate(8'd0, 16'h8000, 1'b1);    // changed rate redraws
    send_rate(8'd170, 16'h5555, 1'b0);
    send_rate(8'd85, 16'hAAAA, 1'b1);
    settle();

    // inverted range, zero step: spikes only for times already passed
    configure(48'd0, 48'hFFFFFF, 48'd0, 48'd0);
    send_rate(8'd2, 16'h8000, 1'b1);
    send_rate(8'd2, 16'h8000, 1'b1);
    send_rate(8'd4, 16'h7FFF, 1'b0);
    settle();

    // random phases over several settings
    configure(48'd1677, 48'd0, 48'hFFFFFF, 48'hFFFFFFFFFFFF);
    random_run(100);
    settle();
    configure(48'd16777, 48'hFFFFFF, 48'd2560000, 48'h5DEECE66D);
    hold_go = 1;
    random_run(100);
    settle();
    configure(48'd1, 48'd0, 48'hFFFFFF, 48'h1);
    random_run(40);
    settle();
    configure(48'd16777216, 48'd0, 48'd512, 48'hA5A5A5A5A5A5);
    random_run(100);
    settle();
    configure(48'd8388608, 48'd100, 48'd1800, 48'h123456789ABC);
    random_run(110);
    settle();

    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* files.f */
src/pse_pkg.sv
src/pse_ram.sv
src/pse_div.sv
src/poisson_spike_encoder_core.sv
test/poisson_spike_encoder_core_test.sv
